// ===== sv/frapq_pkg.sv =====
// shared types and constants for the fenwick range-add / point-query core
// request field layout, operation kinds, controller states, command and status bundles
// no dependencies
package frapq_pkg;

    localparam int unsigned POSITIONS_DEF = 65536;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 17;
    localparam int SUM_W    = 32;

    localparam int FIRST_LSB  = 0;
    localparam int LAST_LSB   = FIRST_LSB + IDX_W;
    localparam int AMOUNT_LSB = LAST_LSB + IDX_W;
    localparam int REQ_BITS   = AMOUNT_LSB + SUM_W;
    localparam int S_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_POINT_ADD = 3'd0,
        KIND_RANGE_ADD = 3'd1,
        KIND_PREFIX    = 3'd2,
        KIND_RANGE_SUM = 3'd3,
        KIND_SET       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADD_CHK,
        ST_ADD_WR,
        ST_PRE_CHK,
        ST_PRE_ACC,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_FIRST,
        POS_LAST_INC,
        POS_LAST_CLAMP,
        POS_FIRST_DEC,
        POS_UP,
        POS_DOWN
    } pos_op_t;

    typedef enum logic [1:0] {
        VAL_HOLD,
        VAL_AMOUNT,
        VAL_NEG,
        VAL_DIFF
    } val_op_t;

    typedef enum logic {
        OUT_ACC,
        OUT_DIFF
    } out_sel_t;

    typedef struct packed {
        logic     req_load;
        logic     clr_step;
        pos_op_t  pos_op;
        val_op_t  val_op;
        logic     acc_clr;
        logic     acc_add;
        logic     hold_save;
        logic     mem_rd;
        logic     mem_wr;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  pos_zero;
        logic  pos_valid;
        logic  first_valid;
        logic  clr_last;
        logic  out_free;
    } sts_t;

endpackage

// ===== sv/frapq_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module frapq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/frapq_dp.sv =====
// datapath: request registers, node position, accumulators, output register, tree ram
// depends on frapq_pkg and frapq_ram
module frapq_dp #(
    parameter int unsigned POSITIONS = frapq_pkg::POSITIONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [frapq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [frapq_pkg::KIND_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [frapq_pkg::SUM_W-1:0]     m_tdata,
    input  frapq_pkg::cmd_t                 cmd,
    output frapq_pkg::sts_t                 sts
);
    import frapq_pkg::*;

    localparam int AW = $clog2(POSITIONS);
    localparam int PW = ($clog2(POSITIONS) + 2 > IDX_W + 1) ? $clog2(POSITIONS) + 2 : IDX_W + 1;
    localparam logic [PW-1:0] POS_MAX = PW'(POSITIONS);
    localparam logic [AW-1:0] CLR_LAST = AW'(POSITIONS - 1);

    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  last_reg;
    logic [SUM_W-1:0]  amount_reg;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  hold_reg;
    logic [SUM_W-1:0]  val_reg, val_next;
    logic [AW-1:0]     clr_reg;
    logic [SUM_W-1:0]  out_data_reg;
    logic              out_valid_reg, out_valid_next;

    logic [PW-1:0]     first_ext, last_ext, last_clamp, first_dec, low_bit;
    logic [AW-1:0]     node_addr;
    logic [SUM_W-1:0]  node_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SUM_W-1:0]  mem_wdata;

    always_comb begin
        first_ext  = PW'(first_reg);
        last_ext   = PW'(last_reg);
        last_clamp = (last_ext > POS_MAX) ? POS_MAX : last_ext;
        if (first_reg == '0) begin
            first_dec = '0;
        end else if (first_ext - PW'(1) > POS_MAX) begin
            first_dec = POS_MAX;
        end else begin
            first_dec = first_ext - PW'(1);
        end
        low_bit   = pos_reg & (~pos_reg + PW'(1));
        node_addr = AW'(pos_reg - PW'(1));
    end

    // node position walk
    always_comb begin
        unique case (cmd.pos_op)
            POS_FIRST:      pos_next = first_ext;
            POS_LAST_INC:   pos_next = last_ext + PW'(1);
            POS_LAST_CLAMP: pos_next = last_clamp;
            POS_FIRST_DEC:  pos_next = first_dec;
            POS_UP:         pos_next = pos_reg + low_bit;
            POS_DOWN:       pos_next = pos_reg - low_bit;
            default:        pos_next = pos_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.val_op)
            VAL_AMOUNT: val_next = amount_reg;
            VAL_NEG:    val_next = ~amount_reg + SUM_W'(1);
            VAL_DIFF:   val_next = amount_reg - acc_reg;
            default:    val_next = val_reg;
        endcase
    end

    always_comb begin
        if (cmd.acc_clr) begin
            acc_next = '0;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + node_data;
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            kind_reg   <= s_tuser;
            first_reg  <= s_tdata[FIRST_LSB +: IDX_W];
            last_reg   <= s_tdata[LAST_LSB +: IDX_W];
            amount_reg <= s_tdata[AMOUNT_LSB +: SUM_W];
        end
        if (cmd.hold_save) begin
            hold_reg <= acc_reg;
        end
        if (cmd.out_load) begin
            out_data_reg <= (cmd.out_sel == OUT_DIFF) ? hold_reg - acc_reg : acc_reg;
        end
        pos_reg <= pos_next;
        acc_reg <= acc_next;
        val_reg <= val_next;
    end

    // clear sweep address and output valid
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + AW'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        mem_we    = cmd.mem_wr || cmd.clr_step;
        mem_waddr = cmd.clr_step ? clr_reg : node_addr;
        mem_wdata = cmd.clr_step ? '0 : node_data + val_reg;
    end

    frapq_ram #(
        .WIDTH (SUM_W),
        .DEPTH (POSITIONS)
    ) u_tree (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (cmd.mem_rd),
        .rd_addr (node_addr),
        .rd_data (node_data)
    );

    always_comb begin
        sts.kind        = kind_t'(kind_reg);
        sts.pos_zero    = (pos_reg == '0);
        sts.pos_valid   = (pos_reg != '0) && (pos_reg <= POS_MAX);
        sts.first_valid = (first_reg != '0) && (first_ext <= POS_MAX);
        sts.clr_last    = (clr_reg == CLR_LAST);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/frapq_ctrl.sv =====
// controller: sequences tree walks for each request kind
// depends on frapq_pkg
module frapq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output frapq_pkg::cmd_t cmd,
    input  frapq_pkg::sts_t sts
);
    import frapq_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    phase_next   = 1'b0;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.kind)
                    KIND_POINT_ADD, KIND_RANGE_ADD: begin
                        cmd.pos_op = POS_FIRST;
                        cmd.val_op = VAL_AMOUNT;
                        state_next = ST_ADD_CHK;
                    end
                    KIND_PREFIX, KIND_RANGE_SUM: begin
                        cmd.pos_op  = POS_LAST_CLAMP;
                        cmd.acc_clr = 1'b1;
                        state_next  = ST_PRE_CHK;
                    end
                    KIND_SET: begin
                        if (sts.first_valid) begin
                            cmd.pos_op  = POS_FIRST;
                            cmd.acc_clr = 1'b1;
                            state_next  = ST_PRE_CHK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ADD_CHK: begin
                if (sts.pos_valid) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_ADD_WR;
                end else if (sts.kind == KIND_RANGE_ADD && !phase_reg) begin
                    // second climb subtracts just past the range end
                    cmd.pos_op = POS_LAST_INC;
                    cmd.val_op = VAL_NEG;
                    phase_next = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR: begin
                cmd.mem_wr = 1'b1;
                cmd.pos_op = POS_UP;
                state_next = ST_ADD_CHK;
            end
            ST_PRE_CHK: begin
                if (!sts.pos_zero) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_PRE_ACC;
                end else if (sts.kind == KIND_SET) begin
                    // climb again with the difference to the current value
                    cmd.val_op = VAL_DIFF;
                    cmd.pos_op = POS_FIRST;
                    phase_next = 1'b1;
                    state_next = ST_ADD_CHK;
                end else if (sts.kind == KIND_RANGE_SUM && !phase_reg) begin
                    cmd.hold_save = 1'b1;
                    cmd.acc_clr   = 1'b1;
                    cmd.pos_op    = POS_FIRST_DEC;
                    phase_next    = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_PRE_ACC: begin
                cmd.acc_add = 1'b1;
                cmd.pos_op  = POS_DOWN;
                state_next  = ST_PRE_CHK;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = (sts.kind == KIND_RANGE_SUM) ? OUT_DIFF : OUT_ACC;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/fenwick_range_add_point_query_core.sv =====
// top level of the fenwick range-add / point-query core
// depends on frapq_pkg, frapq_ctrl, frapq_dp (which holds the tree ram)
//
// A binary indexed tree over positions 1..POSITIONS, each node a 32-bit
// wrapping sum, kept in one simple dual-port ram with a registered read.
// Requests come in on the s_ side; prefix sum and range sum requests give
// one result on the m_ side, all other kinds give none. After reset the core
// sweeps the ram to zero, one node per cycle, and holds s_tready low until
// that pass ends. Requests are handled one at a time. A tree walk visits
// each node with a ram read, then an accumulate or write back, and a walk
// visits at most log2(POSITIONS)+1 nodes. A set value at a dropped position
// and a spare kind leave the tree alone. A sum request also waits in its
// output step while an earlier result has not yet drained. A finished result
// sits in the output register, so the next request is taken while the result
// waits for m_tready.
module fenwick_range_add_point_query_core #(
    parameter int unsigned POSITIONS = frapq_pkg::POSITIONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_index [16:0], last_index [33:17], amount [65:34], zero pad
    input  logic [frapq_pkg::S_TDATA_W-1:0] s_tdata,
    // kind [2:0]
    input  logic [frapq_pkg::KIND_W-1:0]    s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sum_value [31:0]
    output logic [frapq_pkg::SUM_W-1:0]     m_tdata
);
    import frapq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // state machine: decodes the request kind and steps the tree walks
    frapq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // request registers, walk position, sums, result register and the tree
    frapq_dp #(
        .POSITIONS (POSITIONS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== sv/frapq_checker.sv =====
// port-level checks for the fenwick core, bound onto the top level
// depends on frapq_pkg and fenwick_range_add_point_query_core
module frapq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [frapq_pkg::SUM_W-1:0] m_tdata
);

    // a stalled result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: no request taken right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

    // reset starts the clearing pass and drops any result
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("core ready or result shown right after reset");

    // a result is loaded only from the output step, never while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared out of an idle cycle");

endmodule

bind fenwick_range_add_point_query_core frapq_checker u_frapq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/fenwick_range_add_point_query_core_tb.sv =====
// self-checking testbench for fenwick_range_add_point_query_core
// keeps its own binary indexed tree in step with every accepted request and checks each sum
// depends on frapq_pkg and the core rtl only
module fenwick_range_add_point_query_core_tb;
    import frapq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TREE_SIZE = POSITIONS_DEF;
    localparam int unsigned IDX_MAX   = (1 << IDX_W) - 1;
    localparam int          TREE_AW   = $clog2(TREE_SIZE);

    // kinds the core must accept and drop without a result
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_TICKS = 200;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // request channel, all driven to known values from time zero
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;

    // result channel
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SUM_W-1:0]     m_tdata;

    // shadow tree: entry p-1 holds the node for position p, zero like the core after reset
    bit [SUM_W-1:0] shadow_tree [TREE_SIZE];

    // sums the core still owes us, oldest first
    bit [SUM_W-1:0] pending_sums [$];

    // idle percentages for the two sides, changed by the tests
    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;

    int mismatch_count = 0;
    int sums_checked   = 0;
    int requests_sent  = 0;
    int kind_count [8];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    fenwick_range_add_point_query_core #(
        .POSITIONS (TREE_SIZE)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // shadow tree arithmetic, all sums wrap modulo 2^32
    // ------------------------------------------------------------------

    // climb by the lowest set bit; position zero or past the end changes nothing
    function automatic void shadow_add(int unsigned pos, bit [SUM_W-1:0] delta);
        int unsigned p;
        p = pos;
        while (p != 0 && p <= TREE_SIZE) begin
            shadow_tree[TREE_AW'(p - 1)] += delta;
            p += p & (~p + 1);
        end
    endfunction

    // descend by the lowest set bit; past the end means the whole tree
    function automatic bit [SUM_W-1:0] shadow_prefix(int unsigned pos);
        int unsigned    p;
        bit [SUM_W-1:0] acc;
        p   = (pos > TREE_SIZE) ? TREE_SIZE : pos;
        acc = '0;
        while (p != 0) begin
            acc += shadow_tree[TREE_AW'(p - 1)];
            p -= p & (~p + 1);
        end
        return acc;
    endfunction

    // apply one accepted request to the shadow tree, queue the sum it owes
    function automatic void apply_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] first_idx,
                                          logic [IDX_W-1:0] last_idx, logic [SUM_W-1:0] amount);
        bit [SUM_W-1:0] below;
        unique case (kind)
            KIND_POINT_ADD: shadow_add(32'(first_idx), amount);
            KIND_RANGE_ADD: begin
                // the end marker goes one past the range, dropped when past the tree
                shadow_add(32'(first_idx), amount);
                shadow_add(32'(last_idx) + 32'd1, ~amount + 32'd1);
            end
            KIND_PREFIX: pending_sums.push_back(shadow_prefix(32'(last_idx)));
            KIND_RANGE_SUM: begin
                // prefix of zero is zero, reversed ranges simply wrap
                below = (first_idx == 0) ? '0 : shadow_prefix(32'(first_idx) - 32'd1);
                pending_sums.push_back(shadow_prefix(32'(last_idx)) - below);
            end
            KIND_SET: begin
                if (first_idx != 0 && first_idx <= TREE_SIZE)
                    shadow_add(32'(first_idx), amount - shadow_prefix(32'(first_idx)));
            end
            default: ; // spare kinds are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // drive one request and hold it until the core takes it; tvalid stays high
    // between back-to-back requests and only drops for an idle burst
    task automatic send_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] first_idx,
                                logic [IDX_W-1:0] last_idx, logic [SUM_W-1:0] amount);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[FIRST_LSB +: IDX_W]  = first_idx;
        word[LAST_LSB +: IDX_W]   = last_idx;
        word[AMOUNT_LSB +: SUM_W] = amount;
        if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        // taken at this edge
        apply_request(kind, first_idx, last_idx, amount);
        requests_sent++;
        kind_count[kind]++;
    endtask

    // index mix: small positions most often so requests overlap, then power-of-two
    // boundaries, the whole tree, its last position, a few past the end; a set window overrides
    function automatic logic [IDX_W-1:0] pick_index(int unsigned window);
        int unsigned roll;
        int unsigned sh;
        if (window != 0)
            return IDX_W'($urandom_range(0, window));
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return IDX_W'($urandom_range(0, 40));
        if (roll < 65) begin
            sh = $urandom_range(0, IDX_W - 1);
            return IDX_W'((1 << sh) + $urandom_range(0, 2) - 1);
        end
        if (roll < 92)
            return IDX_W'($urandom_range(0, TREE_SIZE));
        if (roll < 96)
            return IDX_W'(TREE_SIZE);
        return IDX_W'($urandom_range(TREE_SIZE + 1, IDX_MAX));
    endfunction

    function automatic logic [SUM_W-1:0] pick_amount();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom();
        if (roll < 85)
            return $urandom_range(0, 16) - 32'd8;
        unique case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // query_pct is the share of sum requests, the rest are updates and a few spare kinds
    function automatic logic [KIND_W-1:0] pick_kind(int unsigned query_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < query_pct)
            return ($urandom_range(0, 1) != 0) ? KIND_PREFIX : KIND_RANGE_SUM;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return KIND_POINT_ADD;
        if (roll < 75)
            return KIND_RANGE_ADD;
        if (roll < 94)
            return KIND_SET;
        return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    endfunction

    task automatic send_random(int unsigned query_pct, int unsigned window);
        send_request(pick_kind(query_pct), pick_index(window), pick_index(window), pick_amount());
    endtask

    function automatic int unsigned pick_idle_pct();
        unique case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // m_tready drops for a burst of random length with chance sink_stall_pct, one assignment per edge
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s, sum_value expected %h got %h",
                     $time, what, want, got);
    endtask

    // every result taken is compared with the oldest sum still owed
    bit [SUM_W-1:0] owed_sum;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                note_mismatch("result with no sum request pending", 'x, m_tdata);
            end else begin
                owed_sum = pending_sums.pop_front();
                sums_checked++;
                if (m_tdata !== owed_sum)
                    note_mismatch("wrong sum", owed_sum, m_tdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // edges of the fields, each kind, and every special case of the tree
    task automatic test_directed_cases();
        send_gap_pct   = 25;
        sink_stall_pct = 25;
        // empty tree, prefix of zero and of the whole tree
        send_request(KIND_PREFIX, '0, '0, '0);
        send_request(KIND_PREFIX, '0, IDX_W'(TREE_SIZE), '0);
        // first and last positions with extreme amounts
        send_request(KIND_POINT_ADD, 17'd1, '0, 32'h7FFF_FFFF);
        send_request(KIND_POINT_ADD, IDX_W'(TREE_SIZE), '0, 32'h8000_0000);
        // adds at position zero and past the end are dropped
        send_request(KIND_POINT_ADD, '0, '0, 32'd123);
        send_request(KIND_POINT_ADD, IDX_W'(IDX_MAX), IDX_W'(IDX_MAX), 32'd5);
        send_request(KIND_PREFIX, '0, 17'd1, '0);
        send_request(KIND_PREFIX, '0, IDX_W'(TREE_SIZE - 1), '0);
        // prefix past the end is clamped to the whole tree
        send_request(KIND_PREFIX, '0, IDX_W'(IDX_MAX), '0);
        // range add whose end marker falls past the tree
        send_request(KIND_RANGE_ADD, 17'd2, IDX_W'(TREE_SIZE), 32'hFFFF_FFFF);
        // range add starting at zero: only the end marker lands
        send_request(KIND_RANGE_ADD, '0, 17'd5, 32'd7);
        send_request(KIND_RANGE_ADD, 17'd3, 17'd3, 32'd100);
        // range sums: from zero, single position, reversed
        send_request(KIND_RANGE_SUM, '0, IDX_W'(TREE_SIZE), '0);
        send_request(KIND_RANGE_SUM, 17'd3, 17'd3, '0);
        send_request(KIND_RANGE_SUM, 17'd10, 17'd2, '0);
        // set value, including the dropped positions
        send_request(KIND_SET, 17'd3, '0, 32'hAAAA_AAAA);
        send_request(KIND_SET, '0, '0, 32'd9);
        send_request(KIND_SET, IDX_W'(TREE_SIZE + 1), '0, 32'd9);
        send_request(KIND_SET, IDX_W'(TREE_SIZE), IDX_W'(IDX_MAX), 32'h5555_5555);
        send_request(KIND_PREFIX, '0, 17'd3, '0);
        // spare kinds must leave the tree alone and give no result
        send_request(KIND_SPARE_FIRST, IDX_W'(IDX_MAX), IDX_W'(IDX_MAX), 32'hFFFF_FFFF);
        send_request(KIND_SPARE_MID, 17'd1, 17'd1, 32'd1);
        send_request(KIND_SPARE_LAST, 17'd4, 17'd4, 32'h1234_5678);
        send_request(KIND_RANGE_SUM, IDX_W'(TREE_SIZE), IDX_W'(TREE_SIZE), '0);
        send_request(KIND_RANGE_SUM, 17'd1, IDX_W'(IDX_MAX), '0);
    endtask

    // broad random mix, idle rates change every 50 requests so some stretches run clean
    task automatic test_random_mix();
        for (int n = 0; n < 1100; n++) begin
            if (n % 50 == 0) begin
                send_gap_pct   = pick_idle_pct();
                sink_stall_pct = pick_idle_pct();
            end
            send_random(40, 0);
        end
    endtask

    // dense small window, mostly sums, no request gaps and a slow sink, so a
    // result waits in the output register while the next request is worked on
    task automatic test_result_backpressure();
        send_gap_pct   = 0;
        sink_stall_pct = 70;
        for (int n = 0; n < 350; n++)
            send_random(70, 24);
    endtask

    // last stretch at full rate on both sides
    task automatic test_unthrottled_tail();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        for (int n = 0; n < 250; n++)
            send_random(45, 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // s_tready stays low through the clearing pass, send_request waits on it

        test_directed_cases();
        test_random_mix();
        test_result_backpressure();
        test_unthrottled_tail();

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        // any stray result would show up within a few walk lengths
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("sent %0d requests: point add %0d, range add %0d, prefix %0d, range sum %0d,",
                 requests_sent, kind_count[KIND_POINT_ADD], kind_count[KIND_RANGE_ADD],
                 kind_count[KIND_PREFIX], kind_count[KIND_RANGE_SUM]);
        $display("set value %0d, spare kinds %0d; %0d sums checked, %0d mismatches",
                 kind_count[KIND_SET],
                 kind_count[KIND_SPARE_FIRST] + kind_count[KIND_SPARE_MID]
                     + kind_count[KIND_SPARE_LAST],
                 sums_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog: a run that has not finished by this time is reported as a failure
    initial begin
        #2_000_000;
        $display("timeout with %0d sums still pending", pending_sums.size());
        $display("status: fail");
        $finish;
    end

endmodule
